>>> rtl/rdc_pkg.sv
package rdc_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int STACK_DEPTH = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int APB_AW      = 2;
  localparam int APB_DW      = 32;

  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CALC_W      = (VALUE_BITS > CHAR_W) ? VALUE_BITS : CHAR_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR   = 7'h30;
  localparam logic [CHAR_W-1:0]  ALPHA_BASE  = 7'h61;

  localparam logic [APB_AW-1:0]  ADDR_RADIX  = 2'd0;

  localparam logic [63:0] VAL_SPAN = 64'd1 << VALUE_BITS;

  // Scaled reciprocals floor(2^VALUE_BITS / r); the quotient estimate is low by at most one.
  localparam logic [VALUE_BITS-1:0] RECIP_TBL [37] = '{
    '0, '0,
    VALUE_BITS'(VAL_SPAN / 2),  VALUE_BITS'(VAL_SPAN / 3),  VALUE_BITS'(VAL_SPAN / 4),
    VALUE_BITS'(VAL_SPAN / 5),  VALUE_BITS'(VAL_SPAN / 6),  VALUE_BITS'(VAL_SPAN / 7),
    VALUE_BITS'(VAL_SPAN / 8),  VALUE_BITS'(VAL_SPAN / 9),  VALUE_BITS'(VAL_SPAN / 10),
    VALUE_BITS'(VAL_SPAN / 11), VALUE_BITS'(VAL_SPAN / 12), VALUE_BITS'(VAL_SPAN / 13),
    VALUE_BITS'(VAL_SPAN / 14), VALUE_BITS'(VAL_SPAN / 15), VALUE_BITS'(VAL_SPAN / 16),
    VALUE_BITS'(VAL_SPAN / 17), VALUE_BITS'(VAL_SPAN / 18), VALUE_BITS'(VAL_SPAN / 19),
    VALUE_BITS'(VAL_SPAN / 20), VALUE_BITS'(VAL_SPAN / 21), VALUE_BITS'(VAL_SPAN / 22),
    VALUE_BITS'(VAL_SPAN / 23), VALUE_BITS'(VAL_SPAN / 24), VALUE_BITS'(VAL_SPAN / 25),
    VALUE_BITS'(VAL_SPAN / 26), VALUE_BITS'(VAL_SPAN / 27), VALUE_BITS'(VAL_SPAN / 28),
    VALUE_BITS'(VAL_SPAN / 29), VALUE_BITS'(VAL_SPAN / 30), VALUE_BITS'(VAL_SPAN / 31),
    VALUE_BITS'(VAL_SPAN / 32), VALUE_BITS'(VAL_SPAN / 33), VALUE_BITS'(VAL_SPAN / 34),
    VALUE_BITS'(VAL_SPAN / 35), VALUE_BITS'(VAL_SPAN / 36)
  };

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic [VALUE_BITS-1:0] recip;
  } rdc_entry_t;

endpackage

>>> rtl/radix_convert_to_digits.sv
// An accepted request is registered in the front stage, held in the queue, then
// loaded by the back end. Each digit is divided by a reciprocal multiply, then a
// remainder correction, then read from the digit stack and presented; a stalled
// output holds the back end. The back end takes a new request only once the last
// digit of the previous one is presented, since divider and stack port are shared.
// Reset: the radix register returns to ten, the queue and digit count are emptied, and the
// digit stack contents stay undefined until written.
module radix_convert_to_digits
  import rdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic [DIGIT_W-1:0]    digit_value_o,
  output logic                  last_digit_o
);

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] radix_d;
  logic [RADIX_W-1:0] wr_radix;
  logic               radix_we;
  logic               fq_valid;
  logic               fq_ready;
  rdc_entry_t         fq_entry;
  logic               qb_valid;
  logic               qb_ready;
  rdc_entry_t         qb_entry;

  assign pready   = 1'b1;
  assign prdata   = APB_DW'(radix_q);
  assign wr_radix = pwdata[RADIX_W-1:0];
  assign radix_we = psel && penable && pwrite && pready && (paddr == ADDR_RADIX);

  always_comb begin
    if (wr_radix < RADIX_MIN) begin
      radix_d = RADIX_MIN;
    end else if (wr_radix > RADIX_MAX) begin
      radix_d = RADIX_MAX;
    end else begin
      radix_d = wr_radix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (radix_we) begin
      radix_q <= radix_d;
    end
  end

  rdc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .radix_i    (radix_q),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_entry_o  (fq_entry)
  );

  rdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_entry_i (fq_entry),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_entry_o  (qb_entry)
  );

  rdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (qb_valid),
    .q_ready_o     (qb_ready),
    .q_entry_i     (qb_entry),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_char_o  (digit_char_o),
    .digit_value_o (digit_value_o),
    .last_digit_o  (last_digit_o)
  );

endmodule

>>> rtl/rdc_front.sv
module rdc_front
  import rdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [RADIX_W-1:0]    radix_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output rdc_entry_t            q_entry_o
);

  logic       full_q;
  rdc_entry_t entry_q;

  assign in_ready_o = !full_q || q_ready_i;
  assign q_valid_o  = full_q;
  assign q_entry_o  = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_ready_o) begin
      full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      entry_q.value <= value_i;
      entry_q.radix <= radix_i;
      entry_q.recip <= RECIP_TBL[radix_i];
    end
  end

endmodule

>>> rtl/rdc_queue.sv
module rdc_queue
  import rdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  rdc_entry_t push_entry_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output rdc_entry_t pop_entry_o
);

  rdc_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> rtl/rdc_back.sv
module rdc_back
  import rdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  rdc_entry_t         q_entry_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic [DIGIT_W-1:0] digit_value_o,
  output logic               last_digit_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_READ,
    S_SEND
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [VALUE_BITS-1:0]     val_q;
  logic [RADIX_W-1:0]        radix_q;
  logic [VALUE_BITS-1:0]     recip_q;
  logic [2*VALUE_BITS-1:0]   prod_q;
  logic [DIGIT_W-1:0]        rd_digit_q;
  logic                      out_valid_q;
  logic [CHAR_W-1:0]         char_q;
  logic [DIGIT_W-1:0]        dval_q;
  logic                      last_q;

  logic [DIGIT_W-1:0]        stack_mem [STACK_DEPTH];

  logic [VALUE_BITS-1:0]     quot_est;
  logic [VALUE_BITS-1:0]     quot;
  logic [CALC_W-1:0]         qr;
  logic [CALC_W-1:0]         rem_raw;
  logic [CALC_W-1:0]         rem_fix;
  logic                      rem_big;
  logic                      push_en;
  logic [CNT_W-1:0]          cnt_dec;
  logic                      send_ok;
  logic [CHAR_W-1:0]         char_d;

  assign quot_est = prod_q[2*VALUE_BITS-1:VALUE_BITS];
  assign qr       = CALC_W'(quot_est) * CALC_W'(radix_q);
  assign rem_raw  = CALC_W'(val_q) - qr;
  assign rem_big  = rem_raw >= CALC_W'(radix_q);
  assign rem_fix  = rem_big ? rem_raw - CALC_W'(radix_q) : rem_raw;
  assign quot     = rem_big ? quot_est + VALUE_BITS'(1) : quot_est;
  assign push_en  = (state_q == S_DIV) && (cnt_q < CNT_W'(STACK_DEPTH));
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign send_ok  = !out_valid_q || out_ready_i;
  assign char_d   = (rd_digit_q < DEC_LIMIT)
                  ? ZERO_CHAR + CHAR_W'(rd_digit_q)
                  : ALPHA_BASE + CHAR_W'(rd_digit_q) - CHAR_W'(DEC_LIMIT);

  assign q_ready_o     = state_q == S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign digit_value_o = dval_q;
  assign last_digit_o  = last_q;

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[cnt_q[STACK_AW-1:0]] <= DIGIT_W'(rem_fix);
    end
    if (state_q == S_READ) begin
      rd_digit_q <= stack_mem[cnt_dec[STACK_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      val_q   <= q_entry_i.value;
      radix_q <= q_entry_i.radix;
      recip_q <= q_entry_i.recip;
    end
    if (state_q == S_MUL) begin
      prod_q <= (2*VALUE_BITS)'(val_q) * (2*VALUE_BITS)'(recip_q);
    end
    if (state_q == S_DIV) begin
      val_q <= quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      dval_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (state_q == S_SEND && send_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (push_en) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          state_q <= (quot == '0) ? S_READ : S_MUL;
        end
        S_READ: begin
          cnt_q   <= cnt_dec;
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (send_ok) begin
            char_q      <= char_d;
            dval_q      <= rd_digit_q;
            last_q      <= cnt_q == '0;
            state_q     <= (cnt_q == '0) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  import rdc_pkg::*;

  localparam int HOLD_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PHASES    = 10;
  localparam int VALUES_PER_PHASE = 18;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 130;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [DIGIT_W-1:0] val;
    logic               last;
  } digit_rec_t;

  class digit_board;
    digit_rec_t  expected_q[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void note_value(logic [VALUE_BITS-1:0] v, logic [RADIX_W-1:0] base);
      logic [DIGIT_W-1:0]    stack [STACK_DEPTH];
      int                    depth;
      logic [VALUE_BITS-1:0] q;
      digit_rec_t            rec;
      depth = 0;
      q = v;
      forever begin
        if (depth < STACK_DEPTH) begin
          stack[depth] = DIGIT_W'(q % base);
          depth++;
        end
        q = q / base;
        if (q == '0) break;
      end
      while (depth > 0) begin
        depth--;
        rec.val  = stack[depth];
        rec.ch   = (stack[depth] >= DEC_LIMIT) ? CHAR_W'(ALPHA_BASE + stack[depth] - DEC_LIMIT)
                                               : CHAR_W'(ZERO_CHAR + stack[depth]);
        rec.last = (depth == 0);
        expected_q.push_back(rec);
      end
    endfunction

    function void check_digit(digit_rec_t got);
      digit_rec_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected digit char %h value %0d last %0b",
                         got.ch, got.val, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.ch !== want.ch)
        report($sformatf("digit_char %h, expected %h", got.ch, want.ch));
      if (got.val !== want.val)
        report($sformatf("digit_value %0d, expected %0d", got.val, want.val));
      if (got.last !== want.last)
        report($sformatf("last_digit %0b, expected %0b", got.last, want.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [VALUE_BITS-1:0] value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CHAR_W-1:0]     digit_char_o;
  logic [DIGIT_W-1:0]    digit_value_o;
  logic                  last_digit_o;

  digit_board         board = new();
  logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
  bit                 idle_on = 1'b1;
  bit                 hold_req = 1'b0;
  int unsigned        values_sent = 0;
  int unsigned        radix_writes = 0;
  int unsigned        holds_done = 0;
  int unsigned        quiet_cycles = 0;

  radix_convert_to_digits dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_char_o  (digit_char_o),
    .digit_value_o (digit_value_o),
    .last_digit_o  (last_digit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] w);
    if (w < RADIX_MIN) return RADIX_MIN;
    if (w > RADIX_MAX) return RADIX_MAX;
    return w;
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value(logic [RADIX_W-1:0] base);
    case ($urandom_range(0, 3))
      0: return VALUE_BITS'($urandom);
      1: return VALUE_BITS'($urandom >> $urandom_range(1, 31));
      2: return VALUE_BITS'($urandom_range(0, int'(base) * int'(base)));
      default: return VALUE_BITS'($urandom) | (VALUE_BITS'(1) << (VALUE_BITS - 1));
    endcase
  endfunction

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_value(v, cur_radix);
    values_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [APB_DW-1:0] w);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_RADIX;
    pwdata  <= w;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_radix = clamp_radix(w[RADIX_W-1:0]);
    radix_writes++;
  endtask

  initial begin
    logic [RADIX_W-1:0] w;
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    value_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The radix after reset is ten.
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value(VALUE_BITS'(9));
    send_value(VALUE_BITS'(10));
    send_value('1);
    send_value(VALUE_BITS'(1000000000));
    drain();
    write_radix(2);
    send_value('1);
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
    drain();
    write_radix(36);
    send_value(VALUE_BITS'(35));
    send_value(VALUE_BITS'(36));
    send_value('1);
    send_value(VALUE_BITS'(1295));
    drain();
    write_radix(0);
    send_value(VALUE_BITS'(5));
    drain();
    write_radix('1);
    send_value(VALUE_BITS'(1295));
    drain();
    write_radix(1);
    send_value(VALUE_BITS'(3));
    drain();
    write_radix(37);
    send_value(VALUE_BITS'(71));
    drain();
    write_radix(16);
    send_value(VALUE_BITS'(255));
    send_value(VALUE_BITS'(256));
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      w = (p % 2 == 1) ? RADIX_W'($urandom_range(2, 36)) : RADIX_W'($urandom_range(0, 63));
      write_radix({(APB_DW - RADIX_W)'($urandom), w});
      if (p == 2) hold_req = 1'b1;
      if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
      for (int i = 0; i < VALUES_PER_PHASE; i++) send_value(random_value(cur_radix));
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run: %0d values converted under %0d radix writes, %0d digits checked",
             values_sent, radix_writes, board.checked);
    $display("run: %0d long output stalls, %0d mismatches", holds_done, board.errors);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_digit('{ch: digit_char_o, val: digit_value_o, last: last_digit_o});
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no request moved for %0d cycles, %0d digits outstanding",
             WATCHDOG_LIMIT, board.pending());
    $display("status: fail");
    $finish;
  end
endmodule

>>> files.f
rtl/rdc_pkg.sv
rtl/rdc_front.sv
rtl/rdc_queue.sv
rtl/rdc_back.sv
rtl/radix_convert_to_digits.sv
tb/tb.sv
